// ----- src/kfet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfet_pkg
// shared constants, codes and types for the keyed fifo eviction table
// ----------------------------------------------------------------------------
package kfet_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 64;
    localparam int DATA_WIDTH  = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int QDEPTH      = 2;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_UPDATE = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_LOOKUP = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // classified request passed from front to back
    typedef enum logic [2:0] {
        OP_ADD, OP_UPDATE, OP_REMOVE, OP_LOOKUP, OP_READ, OP_NOP
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [KEY_WIDTH-1:0]  key;
        logic [5:0]            idx;
        logic [DATA_WIDTH-1:0] data;
    } req_t;
endpackage
`default_nettype wire

// ----- src/kfet_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfet_ram
// generic simple dual-port ram (separate write and read address) with registered read
// ----------------------------------------------------------------------------
module kfet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/kfet_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfet_front
// accepts requests, classifies the action and queues them for the back end
// ----------------------------------------------------------------------------
module kfet_front import kfet_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             stall,
    input  wire logic [2:0]  action,
    input  wire logic [63:0] key,
    input  wire logic [5:0]  slot_index,
    input  wire logic [63:0] entry_data,
    output logic             q_valid,
    output req_t             q_req,
    input  wire logic        q_pop
);
    req_t q_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0]   cnt_reg;
    req_t req;
    logic push;

    always_comb
    begin
        unique case (action)
            ACT_ADD:    req.op = OP_ADD;
            ACT_UPDATE: req.op = OP_UPDATE;
            ACT_REMOVE: req.op = OP_REMOVE;
            ACT_LOOKUP: req.op = OP_LOOKUP;
            ACT_READ:   req.op = OP_READ;
            default:    req.op = OP_NOP;
        endcase
        req.key  = key[KEY_WIDTH-1:0];
        req.idx  = slot_index;
        req.data = entry_data[DATA_WIDTH-1:0];
    end

    assign stall   = (cnt_reg == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != '0);
    assign q_req   = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{$clog2(QDEPTH){1'b0}}, push}
                               - {{$clog2(QDEPTH){1'b0}}, q_pop};
        end
    end
endmodule
`default_nettype wire

// ----- src/kfet_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfet_back
// sequencer that searches, appends to, reads and compacts the key and data stores
// ----------------------------------------------------------------------------
module kfet_back import kfet_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire req_t        q_req,
    output logic             q_pop,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       status,
    output logic             evicted,
    output logic [63:0]      found_key,
    output logic [63:0]      found_data,
    output logic [6:0]       entry_count
);
    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_SHIFT, S_APPEND, S_READ, S_OUT
    } state_t;

    state_t state_reg;
    req_t   req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] ptr_reg;     // address presented to the ram
    logic             rd_ok_reg;   // read data now on rdata (slot prev_reg) is valid
    logic             ev_reg;

    logic                  k_we, d_we;
    logic [IDX_W-1:0]      waddr;
    logic [KEY_WIDTH-1:0]  k_wdata, k_rdata;
    logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
    logic [IDX_W-1:0]      raddr;
    logic [IDX_W-1:0]      prev_reg;   // address of data now on rdata

    kfet_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(k_we), .waddr(waddr), .wdata(k_wdata),
        .raddr(raddr), .rdata(k_rdata));
    kfet_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TABLE_DEPTH)) u_data (
        .clk(clk), .we(d_we), .waddr(waddr), .wdata(d_wdata),
        .raddr(raddr), .rdata(d_rdata));

    logic [CNT_W-1:0] prev_ext, last;
    assign prev_ext = CNT_W'(prev_reg);
    assign last     = count_reg - 1'b1;
    assign raddr    = ptr_reg;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // shift writes rdata (slot prev) into slot prev-1
    always_comb
    begin
        k_we    = 1'b0;
        d_we    = 1'b0;
        waddr   = prev_reg - 1'b1;
        k_wdata = k_rdata;
        d_wdata = d_rdata;
        unique case (state_reg)
            S_SHIFT:
            begin
                k_we = rd_ok_reg;
                d_we = rd_ok_reg;
            end
            S_APPEND:
            begin
                k_we    = 1'b1;
                d_we    = 1'b1;
                waddr   = count_reg[IDX_W-1:0];
                k_wdata = req_reg.key;
                d_wdata = req_reg.data;
            end
            S_SEARCH:
            begin
                d_we    = (req_reg.op == OP_UPDATE) && rd_ok_reg
                          && (k_rdata == req_reg.key);
                waddr   = prev_reg;
                d_wdata = req_reg.data;
            end
            default:
            begin
                k_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            prev_reg    <= '0;
            rd_ok_reg   <= 1'b0;
            ev_reg      <= 1'b0;
            res_valid   <= 1'b0;
            status      <= ST_DONE;
            evicted     <= 1'b0;
            found_key   <= '0;
            found_data  <= '0;
            entry_count <= '0;
            req_reg     <= '0;
        end
        else
        begin
            prev_reg <= ptr_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg   <= q_req;
                        ptr_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        ev_reg    <= 1'b0;
                        status    <= ST_DONE;
                        found_key <= '0;
                        found_data <= '0;
                        unique case (q_req.op)
                            OP_READ:
                            begin
                                if (CNT_W'(q_req.idx) < count_reg)
                                begin
                                    ptr_reg   <= q_req.idx[IDX_W-1:0];
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    status    <= ST_RANGE;
                                    state_reg <= S_OUT;
                                end
                            end
                            OP_NOP:
                            begin
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                if (count_reg == '0)
                                begin
                                    if (q_req.op == OP_ADD)
                                    begin
                                        state_reg <= S_APPEND;
                                    end
                                    else
                                    begin
                                        status    <= ST_NOT_FOUND;
                                        state_reg <= S_OUT;
                                    end
                                end
                                else
                                begin
                                    state_reg <= S_SEARCH;
                                end
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    // rdata holds slot prev_reg when rd_ok_reg is set
                    if (rd_ok_reg && k_rdata == req_reg.key)
                    begin
                        unique case (req_reg.op)
                            OP_ADD:
                            begin
                                status    <= ST_PRESENT;
                                state_reg <= S_OUT;
                            end
                            OP_REMOVE:
                            begin
                                if (prev_ext == last)
                                begin
                                    // removed entry was the last one
                                    count_reg <= count_reg - 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    ptr_reg   <= prev_reg + 1'b1;
                                    rd_ok_reg <= 1'b0;
                                    state_reg <= S_SHIFT;
                                end
                            end
                            OP_LOOKUP:
                            begin
                                found_key  <= 64'(k_rdata);
                                found_data <= 64'(d_rdata);
                                state_reg  <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                    else if (rd_ok_reg && prev_ext == last)
                    begin
                        if (req_reg.op == OP_ADD)
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                ev_reg    <= 1'b1;
                                ptr_reg   <= IDX_W'(1);
                                rd_ok_reg <= 1'b0;
                                state_reg <= S_SHIFT;
                            end
                            else
                            begin
                                state_reg <= S_APPEND;
                            end
                        end
                        else
                        begin
                            status    <= ST_NOT_FOUND;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b1;
                        if (CNT_W'(ptr_reg) != last)
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                end
                S_SHIFT:
                begin
                    // slots above the gap move down one, then the count drops
                    if (rd_ok_reg && prev_ext == last)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= (req_reg.op == OP_ADD) ? S_APPEND : S_OUT;
                    end
                    else if (CNT_W'(ptr_reg) > last)
                    begin
                        // removed entry was the last one
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b1;
                        if (CNT_W'(ptr_reg) != last)
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                end
                S_APPEND:
                begin
                    count_reg <= count_reg + 1'b1;
                    evicted   <= ev_reg;
                    state_reg <= S_OUT;
                end
                S_READ:
                begin
                    if (rd_ok_reg)
                    begin
                        found_key  <= 64'(k_rdata);
                        found_data <= 64'(d_rdata);
                        state_reg  <= S_OUT;
                    end
                    rd_ok_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (!res_valid)
                    begin
                        res_valid   <= 1'b1;
                        entry_count <= 7'(count_reg);
                    end
                    else if (!res_stall)
                    begin
                        res_valid <= 1'b0;
                        evicted   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/keyed_fifo_eviction_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_fifo_eviction_table_top
// insertion-ordered keyed table with oldest-first eviction
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload
//  request  | valid / stall  | action key slot_index entry_data
//  result   | res_valid / res_stall | status evicted found_key found_data entry_count
//
// the key search and the compaction of a request each walk
// the ram read port one slot a cycle
// a two-entry queue takes requests while the sequencer is busy
// reset clears the count and queue; ram contents need no clearing
// a stalled result holds the sequencer in its output state
module keyed_fifo_eviction_table_top import kfet_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             stall,
    input  wire logic [2:0]  action,
    input  wire logic [63:0] key,
    input  wire logic [5:0]  slot_index,
    input  wire logic [63:0] entry_data,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       status,
    output logic             evicted,
    output logic [63:0]      found_key,
    output logic [63:0]      found_data,
    output logic [6:0]       entry_count
);
    logic q_valid, q_pop;
    req_t q_req;

    kfet_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .action(action), .key(key), .slot_index(slot_index),
        .entry_data(entry_data), .q_valid(q_valid), .q_req(q_req),
        .q_pop(q_pop));

    kfet_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .q_pop(q_pop), .res_valid(res_valid), .res_stall(res_stall),
        .status(status), .evicted(evicted), .found_key(found_key),
        .found_data(found_data), .entry_count(entry_count));
endmodule
`default_nettype wire

// ----- src/kfet_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfet_checker
// port-level checks for the keyed fifo eviction table
// ----------------------------------------------------------------------------
module kfet_checker import kfet_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [1:0]  status,
    input wire logic        evicted,
    input wire logic [63:0] found_key,
    input wire logic [6:0]  entry_count
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(found_key))
        else $error("stalled result changed");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> entry_count <= 7'(TABLE_DEPTH))
        else $error("count beyond depth");
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && evicted |-> status == ST_DONE && entry_count == 7'(TABLE_DEPTH))
        else $error("eviction with bad status or count");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_DONE |-> found_key == '0 && !evicted)
        else $error("failed request carried data");
endmodule

bind keyed_fifo_eviction_table_top kfet_checker u_checker (
    .clk(clk), .rst_n(rst_n), .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .evicted(evicted), .found_key(found_key),
    .entry_count(entry_count));
`default_nettype wire
